### design/llmd_pkg.sv
// ============================================================================
// llmd_pkg : shared types and constants for the line distance pipeline
// Register indexes, status codes, multiplier digit size and the side-band
// tag that travels beside the divider and square root stages.
// ============================================================================
package llmd_pkg;

    // digit size of the pipelined multipliers (bits of B per stage)
    localparam int MUL_DIGIT = 8;

    // width of the singular threshold register
    localparam int LIMIT_W = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_PX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_PY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_PZ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DZ     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SING_LIMIT = 3'd6;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_SKEW     = 2'd0;
    localparam t_status ST_PARALLEL = 2'd1;
    localparam t_status ST_ZERO_DIR = 2'd2;

    // flags carried alongside the divide / root pipeline
    typedef struct packed {
        t_status status;
        logic    sat;
        logic    zero;
    } t_tag;

endpackage

### design/llmd_if.sv
// ============================================================================
// llmd_if : channel interfaces of the line distance block
// Query line channel, result channel and configuration write channel.
// ============================================================================
interface llmd_line_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] other_px;
    logic signed [CW-1:0] other_py;
    logic signed [CW-1:0] other_pz;
    logic signed [CW-1:0] other_dx;
    logic signed [CW-1:0] other_dy;
    logic signed [CW-1:0] other_dz;

    modport source (output valid, output other_px, output other_py, output other_pz,
                    output other_dx, output other_dy, output other_dz, input ready);
    modport sink   (input valid, input other_px, input other_py, input other_pz,
                    input other_dx, input other_dy, input other_dz, output ready);
endinterface

interface llmd_res_if #(parameter int CW = 32);
    logic                   valid;
    logic                   ready;
    logic [CW-1:0]          distance;
    llmd_pkg::t_status      status;
    logic                   saturated;

    modport source (output valid, output distance, output status, output saturated,
                    input ready);
    modport sink   (input valid, input distance, input status, input saturated,
                    output ready);
endinterface

interface llmd_cfg_if #(parameter int DW = 32);
    logic                           valid;
    logic                           ready;
    logic [llmd_pkg::CFG_IDX_W-1:0] index;
    logic [DW-1:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/llmd_mul.sv
// ============================================================================
// llmd_mul : pipelined signed multiplier
// Magnitudes are registered, then one MUL_DIGIT-bit digit of B is
// multiplied and accumulated per stage; the sign is applied in the last stage.
// ============================================================================
module llmd_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int DIG = llmd_pkg::MUL_DIGIT;
    localparam int ND  = (WB + DIG - 1) / DIG;
    localparam int BW  = ND * DIG;
    localparam int PW  = WA + WB;

    logic [WA-1:0]        n_amag;
    logic [WB-1:0]        n_bmag;
    logic [WA+DIG-1:0]    n_pp  [ND];
    logic [WA-1:0]        r_a   [ND];
    logic [BW-1:0]        r_b   [ND];
    logic                 r_neg [ND+1];
    logic [PW-1:0]        r_acc [ND+1];
    logic signed [PW-1:0] r_p;

    // magnitudes and per-stage partial products
    always_comb begin
        n_amag = i_a[WA-1] ? WA'(-i_a) : WA'(i_a);
        n_bmag = i_b[WB-1] ? WB'(-i_b) : WB'(i_b);
        for (int k = 0; k < ND; k++) begin
            n_pp[k] = r_a[k] * r_b[k][k*DIG +: DIG];
        end
    end

    // digit-serial accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]   <= n_amag;
            r_b[0]   <= BW'(n_bmag);
            r_neg[0] <= i_a[WA-1] ^ i_b[WB-1];
            r_acc[0] <= '0;
            for (int k = 0; k < ND - 1; k++) begin
                r_a[k+1] <= r_a[k];
                r_b[k+1] <= r_b[k];
            end
            for (int k = 0; k < ND; k++) begin
                r_neg[k+1] <= r_neg[k];
                r_acc[k+1] <= r_acc[k] + (PW'(n_pp[k]) << (k * DIG));
            end
            r_p <= r_neg[ND] ? -$signed(r_acc[ND]) : $signed(r_acc[ND]);
        end
    end

    assign o_p = r_p;

endmodule

### design/llmd_dly.sv
// ============================================================================
// llmd_dly : enabled delay line
// Shifts data through a chain of enabled registers to align side paths with the multipliers.
// ============================================================================
module llmd_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [D];

    // shift on every enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[D-1];

endmodule

### design/llmd_div.sv
// ============================================================================
// llmd_div : pipelined restoring divider
// Produces QW quotient bits of (i_rem:i_low) / i_den, one bit per stage.
// The caller guarantees i_rem < i_den.
// ============================================================================
module llmd_div #(
    parameter int DW = 134,
    parameter int QW = 64
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_q
);
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic [DW:0]   n_t   [QW];
    logic          n_ge  [QW];

    // trial subtract per stage
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            n_t[k]  = {r_rem[k], r_low[k][QW-1]};
            n_ge[k] = n_t[k] >= {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_rem;
            r_low[0] <= i_low;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1] <= n_ge[k] ? DW'(n_t[k] - {1'b0, r_den[k]}) : DW'(n_t[k]);
                r_low[k+1] <= r_low[k] << 1;
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= {r_q[k][QW-2:0], n_ge[k]};
            end
        end
    end

    assign o_q = r_q[QW];

endmodule

### design/llmd_sqrt.sv
// ============================================================================
// llmd_sqrt : pipelined integer square root
// floor(sqrt(i_q)) by the digit-by-digit method, one root bit per stage.
// ============================================================================
module llmd_sqrt #(
    parameter int CW = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*CW-1:0] i_q,
    output logic [CW-1:0]   o_root
);
    localparam int RW = CW + 2;

    logic [2*CW-1:0] r_v    [CW+1];
    logic [RW-1:0]   r_rem  [CW+1];
    logic [CW-1:0]   r_root [CW+1];
    logic [RW+1:0]   n_t    [CW];
    logic [RW+1:0]   n_trial[CW];
    logic            n_ge   [CW];

    // compare against 4*root + 1
    always_comb begin
        for (int k = 0; k < CW; k++) begin
            n_t[k]     = {r_rem[k], r_v[k][2*CW-1 -: 2]};
            n_trial[k] = (RW+2)'({r_root[k], 2'b01});
            n_ge[k]    = n_t[k] >= n_trial[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= i_q;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int k = 0; k < CW; k++) begin
                r_v[k+1]    <= r_v[k] << 2;
                r_rem[k+1]  <= n_ge[k] ? RW'(n_t[k] - n_trial[k]) : RW'(n_t[k]);
                r_root[k+1] <= {r_root[k][CW-2:0], n_ge[k]};
            end
        end
    end

    assign o_root = r_root[CW];

endmodule

### design/line_line_min_distance.sv
// ============================================================================
// line_line_min_distance : shortest distance between two 3-D lines
// Reference line held in registers; each query line yields one distance.
// ============================================================================
//  channel   dir  handshake     payload
//  i_line    in   valid/ready   other_px..other_pz, other_dx..other_dz
//  o_res     out  valid/ready   distance, status, saturated
//  i_cfg     in   valid/ready   index, data (ready high out of reset)
//
//  One query per cycle while o_res is not stalled. The pipeline depth is
//  set by the digit-serial multipliers and the one-bit-per-stage divider
//  and square root.
//  Reset (sync, active low) clears valid bits and loads register defaults.
//  A stall on o_res freezes every stage at once; nothing is dropped.
// ============================================================================
module line_line_min_distance #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    llmd_line_if.sink    i_line,
    llmd_res_if.source   o_res,
    llmd_cfg_if.sink     i_cfg
);
    localparam int CW  = COORD_WIDTH;
    localparam int WW  = CW + 1;
    localparam int E   = 2 * CW + 2;
    localparam int SW  = 2 * E + 2;
    localparam int NW  = 2 * SW;
    localparam int DW  = SW;
    localparam int QW  = 2 * CW;
    localparam int LW  = llmd_pkg::LIMIT_W;
    localparam int DIG = llmd_pkg::MUL_DIGIT;
    localparam int TS  = 3 * FRAC_BITS;
    localparam int TW  = (DW > LW + TS) ? DW : LW + TS;
    localparam int L1  = (CW + DIG - 1) / DIG + 2;
    localparam int L3  = (E + DIG - 1) / DIG + 2;
    localparam int L5  = (SW + DIG - 1) / DIG + 2;
    localparam int P6  = L1 + L3 + L5 + 3;
    localparam int PO  = P6 + QW + CW + 3;

    // configuration registers
    logic signed [CW-1:0] r_ref_p [3];
    logic signed [CW-1:0] r_ref_d [3];
    logic [LW-1:0]        r_limit;

    logic          en;
    logic [PO:0]   r_vld;

    logic signed [CW-1:0] n0_p2 [3];
    logic signed [CW-1:0] n0_d2 [3];
    logic signed [WW-1:0] r0_w  [3];
    logic signed [CW-1:0] r0_d2 [3];
    logic                 r0_z2;

    logic signed [2*CW-1:0] m1_ca [3];
    logic signed [2*CW-1:0] m1_cb [3];
    logic signed [2*CW:0]   m1_xa [3];
    logic signed [2*CW:0]   m1_xb [3];
    logic signed [2*CW-1:0] m1_dd [3];
    logic signed [WW-1:0]   d1_w  [3];

    logic signed [E-1:0] r2_c [3];
    logic signed [E-1:0] r2_x [3];
    logic signed [E-1:0] r2_w [3];
    logic [DW-1:0]       r2_dd;

    logic signed [2*E-1:0] m3_cc [3];
    logic signed [2*E-1:0] m3_s  [3];
    logic signed [2*E-1:0] m3_nn [3];

    logic [DW-1:0]        r4_cc;
    logic signed [SW-1:0] r4_s;
    logic [DW-1:0]        r4_num;

    logic signed [NW-1:0] m5_ss;
    logic [DW-1:0]        cc_d;
    logic [DW-1:0]        num_d;
    logic [DW-1:0]        dd_d;
    logic                 z2_d;

    logic [TW-1:0]        n6_thr;
    logic                 n6_sing;
    logic                 z1;
    logic [NW-1:0]        r6_n;
    logic [DW-1:0]        r6_d;
    llmd_pkg::t_status    r6_status;
    logic                 r6_zero;

    llmd_pkg::t_tag       r7_tag;
    llmd_pkg::t_tag       tag_d;
    logic [QW-1:0]        q_div;
    logic [CW-1:0]        root;

    logic [CW-1:0]        r_dist;
    llmd_pkg::t_status    r_status;
    logic                 r_sat;

    // whole pipeline advances unless the result register is held
    assign en           = !r_vld[PO] || o_res.ready;
    assign i_line.ready = i_rst_n && en;
    assign i_cfg.ready  = i_rst_n;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_p[0] <= '0;
            r_ref_p[1] <= '0;
            r_ref_p[2] <= '0;
            r_ref_d[0] <= '0;
            r_ref_d[1] <= '0;
            r_ref_d[2] <= CW'(1) << FRAC_BITS;
            r_limit    <= LW'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                llmd_pkg::REG_REF_PX:     r_ref_p[0] <= i_cfg.data[CW-1:0];
                llmd_pkg::REG_REF_PY:     r_ref_p[1] <= i_cfg.data[CW-1:0];
                llmd_pkg::REG_REF_PZ:     r_ref_p[2] <= i_cfg.data[CW-1:0];
                llmd_pkg::REG_REF_DX:     r_ref_d[0] <= i_cfg.data[CW-1:0];
                llmd_pkg::REG_REF_DY:     r_ref_d[1] <= i_cfg.data[CW-1:0];
                llmd_pkg::REG_REF_DZ:     r_ref_d[2] <= i_cfg.data[CW-1:0];
                llmd_pkg::REG_SING_LIMIT: r_limit    <= i_cfg.data[LW-1:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PO-1:0], i_line.valid};
        end
    end

    // stage 0: capture query, W = P1 - P2
    always_comb begin
        n0_p2[0] = i_line.other_px;
        n0_p2[1] = i_line.other_py;
        n0_p2[2] = i_line.other_pz;
        n0_d2[0] = i_line.other_dx;
        n0_d2[1] = i_line.other_dy;
        n0_d2[2] = i_line.other_dz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r0_w[i]  <= WW'(r_ref_p[i]) - WW'(n0_p2[i]);
                r0_d2[i] <= n0_d2[i];
            end
            r0_z2 <= (n0_d2[0] == '0) && (n0_d2[1] == '0) && (n0_d2[2] == '0);
        end
    end

    // phase 1: D1 x D2, W x D1 and D1.D1 products
    for (genvar i = 0; i < 3; i++) begin : g_ph1
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        llmd_mul #(.WA(CW), .WB(CW)) u_ca (
            .i_clk(i_clk), .i_en(en), .i_a(r_ref_d[J]), .i_b(r0_d2[K]), .o_p(m1_ca[i]));
        llmd_mul #(.WA(CW), .WB(CW)) u_cb (
            .i_clk(i_clk), .i_en(en), .i_a(r_ref_d[K]), .i_b(r0_d2[J]), .o_p(m1_cb[i]));
        llmd_mul #(.WA(WW), .WB(CW)) u_xa (
            .i_clk(i_clk), .i_en(en), .i_a(r0_w[J]), .i_b(r_ref_d[K]), .o_p(m1_xa[i]));
        llmd_mul #(.WA(WW), .WB(CW)) u_xb (
            .i_clk(i_clk), .i_en(en), .i_a(r0_w[K]), .i_b(r_ref_d[J]), .o_p(m1_xb[i]));
        llmd_mul #(.WA(CW), .WB(CW)) u_dd (
            .i_clk(i_clk), .i_en(en), .i_a(r_ref_d[i]), .i_b(r_ref_d[i]), .o_p(m1_dd[i]));
        llmd_dly #(.W(WW), .D(L1)) u_wd (
            .i_clk(i_clk), .i_en(en), .i_d(r0_w[i]), .o_q(d1_w[i]));
    end

    // phase 2: cross differences and |D1|^2
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_c[i] <= E'(m1_ca[i]) - E'(m1_cb[i]);
                r2_x[i] <= E'(m1_xa[i]) - E'(m1_xb[i]);
                r2_w[i] <= E'(d1_w[i]);
            end
            r2_dd <= DW'($unsigned(m1_dd[0])) + DW'($unsigned(m1_dd[1]))
                   + DW'($unsigned(m1_dd[2]));
        end
    end

    // phase 3: C.C, W.C and X.X terms
    for (genvar i = 0; i < 3; i++) begin : g_ph3
        llmd_mul #(.WA(E), .WB(E)) u_cc (
            .i_clk(i_clk), .i_en(en), .i_a(r2_c[i]), .i_b(r2_c[i]), .o_p(m3_cc[i]));
        llmd_mul #(.WA(E), .WB(E)) u_s (
            .i_clk(i_clk), .i_en(en), .i_a(r2_w[i]), .i_b(r2_c[i]), .o_p(m3_s[i]));
        llmd_mul #(.WA(E), .WB(E)) u_nn (
            .i_clk(i_clk), .i_en(en), .i_a(r2_x[i]), .i_b(r2_x[i]), .o_p(m3_nn[i]));
    end

    llmd_dly #(.W(DW), .D(L3 + L5 + 1)) u_dd_dly (
        .i_clk(i_clk), .i_en(en), .i_d(r2_dd), .o_q(dd_d));

    // phase 4: sums of three terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cc  <= DW'($unsigned(m3_cc[0])) + DW'($unsigned(m3_cc[1]))
                    + DW'($unsigned(m3_cc[2]));
            r4_s   <= SW'(m3_s[0]) + SW'(m3_s[1]) + SW'(m3_s[2]);
            r4_num <= DW'($unsigned(m3_nn[0])) + DW'($unsigned(m3_nn[1]))
                    + DW'($unsigned(m3_nn[2]));
        end
    end

    // phase 5: (W.C)^2, with side paths aligned
    llmd_mul #(.WA(SW), .WB(SW)) u_ss (
        .i_clk(i_clk), .i_en(en), .i_a(r4_s), .i_b(r4_s), .o_p(m5_ss));
    llmd_dly #(.W(DW), .D(L5)) u_cc_dly (
        .i_clk(i_clk), .i_en(en), .i_d(r4_cc), .o_q(cc_d));
    llmd_dly #(.W(DW), .D(L5)) u_num_dly (
        .i_clk(i_clk), .i_en(en), .i_d(r4_num), .o_q(num_d));
    llmd_dly #(.W(1), .D(L1 + L3 + L5 + 2)) u_z2_dly (
        .i_clk(i_clk), .i_en(en), .i_d(r0_z2), .o_q(z2_d));

    // phase 6: singular test, pick numerator and denominator
    always_comb begin
        z1      = (r_ref_d[0] == '0) && (r_ref_d[1] == '0) && (r_ref_d[2] == '0);
        n6_thr  = TW'(r_limit) << TS;
        n6_sing = (cc_d == '0) || (TW'(cc_d) < n6_thr);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (n6_sing) begin
                r6_n      <= NW'(num_d);
                r6_d      <= dd_d;
                r6_status <= (z1 || z2_d) ? llmd_pkg::ST_ZERO_DIR : llmd_pkg::ST_PARALLEL;
                r6_zero   <= z1 || z2_d;
            end else begin
                r6_n      <= $unsigned(m5_ss);
                r6_d      <= cc_d;
                r6_status <= llmd_pkg::ST_SKEW;
                r6_zero   <= 1'b0;
            end
        end
    end

    // overflow when quotient reaches 2^(2W)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_tag.status <= r6_status;
            r7_tag.zero   <= r6_zero;
            r7_tag.sat    <= r6_n[NW-1:QW] >= (NW-QW)'(r6_d);
        end
    end

    llmd_div #(.DW(DW), .QW(QW)) u_div (
        .i_clk(i_clk), .i_en(en), .i_rem(r6_n[QW +: DW]), .i_low(r6_n[QW-1:0]),
        .i_den(r6_d), .o_q(q_div));

    llmd_sqrt #(.CW(CW)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_q(q_div), .o_root(root));

    llmd_dly #(.W($bits(llmd_pkg::t_tag)), .D(QW + CW + 1)) u_tag_dly (
        .i_clk(i_clk), .i_en(en), .i_d(r7_tag), .o_q(tag_d));

    // result register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= tag_d.status;
            r_sat    <= tag_d.sat && !tag_d.zero;
            if (tag_d.zero) begin
                r_dist <= '0;
            end else if (tag_d.sat) begin
                r_dist <= '1;
            end else begin
                r_dist <= root;
            end
        end
    end

    assign o_res.valid     = r_vld[PO];
    assign o_res.distance  = r_dist;
    assign o_res.status    = r_status;
    assign o_res.saturated = r_sat;

endmodule
